[hw/rtl/svwr_pkg.sv]
// Shared types, constants and elaboration-time table functions for the sine voice.
// No dependencies; used by every other file of the block except svwr_fifo.
`default_nettype none

package svwr_pkg;

	localparam int unsigned PHASE_BITS_DEF = 32;
	localparam int unsigned SAMPLE_RATE    = 48000;
	localparam int unsigned SINE_BITS      = 10;
	localparam int unsigned SINE_QB        = SINE_BITS - 2;
	localparam int unsigned SINE_QN        = 1 << SINE_QB;

	localparam int unsigned GAIN_W = 13;
	localparam int unsigned REL_W  = 17;
	localparam int unsigned MAG_W  = 15;
	localparam int unsigned MUL_W  = 17;
	localparam int unsigned PROD_W = 2 * MUL_W;
	localparam int unsigned SMP_W  = 16;

	localparam logic [REL_W-1:0] REL_ONE   = 17'h10000;
	localparam logic [15:0]      REL_DECAY = 16'd64881;
	localparam logic [REL_W-1:0] REL_FLOOR = 17'd327;

	localparam int unsigned CMDQ_DEPTH = 2;
	localparam int unsigned RESQ_DEPTH = 2;

	localparam logic [1:0] KIND_ON   = 2'd0;
	localparam logic [1:0] KIND_OFF  = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	typedef enum logic [1:0] {
		OP_ON   = 2'd0,
		OP_OFF  = 2'd1,
		OP_TICK = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [GAIN_W-1:0] gain;
		logic              allow;
	} cmd_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample;
		logic                    active;
		logic                    releasing;
	} res_t;

	// Q24 Hz frequencies of MIDI notes 0..11
	localparam logic [63:0] OCT0_Q24 [0:11] = '{
		64'd137167144, 64'd145323527, 64'd153964914, 64'd163120144,
		64'd172819773, 64'd183096171, 64'd193983636, 64'd205518503,
		64'd217739269, 64'd230686720, 64'd244404066, 64'd258937088
	};

	// phase increment per tick for note n, pb phase bits; never zero
	function automatic logic [63:0] step_fn(input int unsigned n, input int unsigned pb);
		logic [63:0] f;
		logic [63:0] q;
		logic [63:0] r;
		int unsigned k;
		f = OCT0_Q24[n % 12] << (n / 12);
		q = f / SAMPLE_RATE;
		r = f % SAMPLE_RATE;
		if (pb >= 24) begin
			for (k = 0; k < pb - 24; k++) begin
				r = r << 1;
				q = q << 1;
				if (r >= 64'(SAMPLE_RATE)) begin
					r = r - 64'(SAMPLE_RATE);
					q = q | 64'd1;
				end
			end
		end else begin
			q = q >> (24 - pb);
		end
		if (pb < 64)
			q = q & ((64'd1 << pb) - 64'd1);
		if (q == 64'd0)
			q = 64'd1;
		return q;
	endfunction

	// Q1.15 gain: 0.2 * v / 127, rounded
	function automatic logic [GAIN_W-1:0] gain_fn(input int unsigned v);
		int unsigned t;
		t = (v * 65536 + 635) / 1270;
		return GAIN_W'(t);
	endfunction

	// |sin| in Q1.15 for quarter-wave offset j (0..SINE_QN), Q30 odd polynomial
	function automatic logic [MAG_W-1:0] sine_mag_fn(input int unsigned j);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] p;
		logic [63:0] v;
		x  = 64'(j) << (30 - SINE_QB);
		x2 = (x * x) >> 30;
		p  = 64'd172273;
		p  = 64'd5026995 - ((x2 * p) >> 30);
		p  = 64'd85569306 - ((x2 * p) >> 30);
		p  = 64'd693598668 - ((x2 * p) >> 30);
		p  = 64'd1686629713 - ((x2 * p) >> 30);
		v  = (x * p) >> 30;
		v  = (v + 64'd16384) >> 15;
		if (v > 64'd32767)
			v = 64'd32767;
		return v[MAG_W-1:0];
	endfunction

endpackage

`default_nettype wire

[hw/rtl/svwr_fifo.sv]
// Small register queue used between front and back end and on the result side.
// No package dependency.
`default_nettype none

module svwr_fifo #(
	parameter int unsigned W     = 1,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         we,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         re,
	output logic [W-1:0]      rdata,
	output logic              empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = we && !full;
	assign do_rd = re && !empty;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_rd)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/svwr_front.sv]
// Front end: classifies an incoming word and looks up its phase step and gain.
// Depends on svwr_pkg (op codes, command type, step and gain table functions).
`default_nettype none

module svwr_front #(
	parameter int unsigned PHASE_BITS = svwr_pkg::PHASE_BITS_DEF
) (
	input  wire logic                   push,
	input  wire logic                   full,
	input  wire logic [1:0]             kind,
	input  wire logic [6:0]             note,
	input  wire logic [6:0]             velocity,
	input  wire logic                   allow_release,
	output logic                        cmd_we,
	output logic [PHASE_BITS-1:0]       cmd_step,
	output svwr_pkg::cmd_t              cmd
);

	import svwr_pkg::*;

	logic [PHASE_BITS-1:0] step_rom [0:127];
	logic [GAIN_W-1:0]     gain_rom [0:127];

	for (genvar g = 0; g < 128; g++) begin : g_rom
		assign step_rom[g] = PHASE_BITS'(step_fn(g, PHASE_BITS));
		assign gain_rom[g] = gain_fn(g);
	end

	assign cmd_we   = push && !full;
	assign cmd_step = step_rom[note];

	always_comb begin
		case (kind)
			KIND_ON:   cmd.op = OP_ON;
			KIND_OFF:  cmd.op = OP_OFF;
			KIND_TICK: cmd.op = OP_TICK;
			default:   cmd.op = OP_NOP;
		endcase
		cmd.gain  = gain_rom[velocity];
		cmd.allow = allow_release;
	end

endmodule

`default_nettype wire

[hw/rtl/svwr_back.sv]
// Back end: voice state, sine lookup and the shared multiplier sequence.
// Depends on svwr_pkg (command and result types, sine table function, constants).
`default_nettype none

module svwr_back #(
	parameter int unsigned PHASE_BITS = svwr_pkg::PHASE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_empty,
	input  wire logic [PHASE_BITS-1:0] cmd_step,
	input  svwr_pkg::cmd_t             cmd,
	output logic                       cmd_pop,
	input  wire logic                  res_full,
	output logic                       res_we,
	output svwr_pkg::res_t             res
);

	import svwr_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_MUL_SG = 4'b0010,   // sine * gain
		ST_MUL_RG = 4'b0100,   // sample * release factor
		ST_MUL_DK = 4'b1000    // release decay
	} state_t;

	state_t                state_q, state_d;
	logic [PHASE_BITS-1:0] phase_q, phase_d;
	logic [PHASE_BITS-1:0] step_q, step_d;
	logic [GAIN_W-1:0]     gain_q, gain_d;
	logic [REL_W-1:0]      rel_q, rel_d;
	logic [MAG_W-1:0]      mag_q, mag_d;
	logic [MAG_W-1:0]      sine_mag_q;
	logic                  sine_neg_q;

	logic [MAG_W-1:0]      sine_rom [0:SINE_QN];
	logic [SINE_BITS-1:0]  idx;
	logic [SINE_QB:0]      qidx;

	logic [MUL_W-1:0]      mul_a, mul_b;
	logic [PROD_W-1:0]     prod, rnd15, rnd16;
	logic [MAG_W-1:0]      mag15, mag16;
	logic [REL_W-1:0]      rel_dec;

	for (genvar g = 0; g <= SINE_QN; g++) begin : g_sine
		assign sine_rom[g] = sine_mag_fn(g);
	end

	function automatic logic signed [SMP_W-1:0] to_sample(input logic neg,
		input logic [MAG_W-1:0] mag);
		logic signed [SMP_W-1:0] s;
		s = $signed(SMP_W'(mag));
		return neg ? -s : s;
	endfunction

	// quarter-wave reflection of the table index
	assign idx  = phase_q[PHASE_BITS-1 -: SINE_BITS];
	assign qidx = idx[SINE_BITS-2] ? ((SINE_QB+1)'(SINE_QN) - {1'b0, idx[SINE_QB-1:0]})
		: {1'b0, idx[SINE_QB-1:0]};

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			sine_mag_q <= sine_rom[qidx];
			sine_neg_q <= idx[SINE_BITS-1];
		end
		mag_q <= mag_d;
	end

	always_comb begin
		case (state_q)
			ST_MUL_SG: begin
				mul_a = MUL_W'(sine_mag_q);
				mul_b = MUL_W'(gain_q);
			end
			ST_MUL_RG: begin
				mul_a = MUL_W'(mag_q);
				mul_b = rel_q;
			end
			ST_MUL_DK: begin
				mul_a = rel_q;
				mul_b = MUL_W'(REL_DECAY);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign rnd15   = prod + PROD_W'(16384);
	assign rnd16   = prod + PROD_W'(32768);
	assign mag15   = rnd15[15 +: MAG_W];
	assign mag16   = rnd16[16 +: MAG_W];
	assign rel_dec = rnd16[16 +: REL_W];

	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		step_d     = step_q;
		gain_d     = gain_q;
		rel_d      = rel_q;
		mag_d      = mag_q;
		cmd_pop    = 1'b0;
		res_we     = 1'b0;
		res.sample = '0;
		case (state_q)
			ST_IDLE: begin
				// result queue room is reserved here; only this block writes it
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						OP_ON: begin
							phase_d = '0;
							gain_d  = cmd.gain;
							rel_d   = '0;
							step_d  = cmd_step;
							res_we  = 1'b1;
						end
						OP_OFF: begin
							if (step_q != '0) begin
								if (cmd.allow) begin
									if (rel_q == '0)
										rel_d = REL_ONE;
								end else begin
									step_d = '0;
									rel_d  = '0;
								end
							end
							res_we = 1'b1;
						end
						OP_TICK: begin
							if (step_q != '0) begin
								phase_d = phase_q + step_q;
								state_d = ST_MUL_SG;
							end else begin
								res_we = 1'b1;
							end
						end
						default: res_we = 1'b1;
					endcase
				end
			end
			ST_MUL_SG: begin
				mag_d = mag15;
				if (rel_q != '0) begin
					state_d = ST_MUL_RG;
				end else begin
					res_we     = 1'b1;
					res.sample = to_sample(sine_neg_q, mag15);
					state_d    = ST_IDLE;
				end
			end
			ST_MUL_RG: begin
				mag_d   = mag16;
				state_d = ST_MUL_DK;
			end
			ST_MUL_DK: begin
				if (rel_dec <= REL_FLOOR) begin
					step_d = '0;
					rel_d  = '0;
				end else begin
					rel_d = rel_dec;
				end
				res_we     = 1'b1;
				res.sample = to_sample(sine_neg_q, mag_q);
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		res.active    = (step_d != '0);
		res.releasing = (rel_d != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			step_q  <= '0;
			gain_q  <= '0;
			rel_q   <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			step_q  <= step_d;
			gain_q  <= gain_d;
			rel_q   <= rel_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/sine_voice_with_release_top.sv]
// One sine oscillator voice with exponential release, queue interface on both sides.
// Words are note on, note off or sample tick; each word gives exactly one result word.
// A note on, note off or tick on a silent voice is done in the idle state. A tick on a
// sounding voice also passes MUL_SG, and MUL_RG and MUL_DK while the release runs: the
// single 17x17 multiplier is used in turn for sine times gain, times release factor, and
// release decay. A two-entry command queue and a two-entry result queue decouple input,
// voice and output; a word and its result are each registered in a queue on the way.
// Depends on svwr_pkg, svwr_fifo, svwr_front and svwr_back.
`default_nettype none

module sine_voice_with_release_top #(
	parameter int unsigned PHASE_BITS = svwr_pkg::PHASE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [1:0]                        kind,
	input  wire logic [6:0]                        note,
	input  wire logic [6:0]                        velocity,
	input  wire logic                              allow_release,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic signed [svwr_pkg::SMP_W-1:0]      sample,
	output logic                                   active,
	output logic                                   releasing
);

	import svwr_pkg::*;

	localparam int unsigned CMD_W = PHASE_BITS + $bits(cmd_t);
	localparam int unsigned RES_W = $bits(res_t);

	logic                  cmd_we;
	logic [PHASE_BITS-1:0] fe_step;
	cmd_t                  fe_cmd;
	logic [CMD_W-1:0]      cmdq_rdata;
	logic                  cmd_empty;
	logic                  cmd_pop;
	logic [PHASE_BITS-1:0] be_step;
	cmd_t                  be_cmd;

	logic                  res_we;
	logic                  res_full;
	res_t                  be_res;
	logic [RES_W-1:0]      resq_rdata;
	res_t                  out_res;

	svwr_front #(
		.PHASE_BITS(PHASE_BITS)
	) u_front (
		.push         (push),
		.full         (full),
		.kind         (kind),
		.note         (note),
		.velocity     (velocity),
		.allow_release(allow_release),
		.cmd_we       (cmd_we),
		.cmd_step     (fe_step),
		.cmd          (fe_cmd)
	);

	svwr_fifo #(
		.W    (CMD_W),
		.DEPTH(CMDQ_DEPTH)
	) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cmd_we),
		.wdata ({fe_step, fe_cmd}),
		.full  (full),
		.re    (cmd_pop),
		.rdata (cmdq_rdata),
		.empty (cmd_empty)
	);

	assign be_step = cmdq_rdata[CMD_W-1 -: PHASE_BITS];
	assign be_cmd  = cmd_t'(cmdq_rdata[$bits(cmd_t)-1:0]);

	svwr_back #(
		.PHASE_BITS(PHASE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd_step (be_step),
		.cmd      (be_cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_we   (res_we),
		.res      (be_res)
	);

	svwr_fifo #(
		.W    (RES_W),
		.DEPTH(RESQ_DEPTH)
	) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (res_we),
		.wdata (be_res),
		.full  (res_full),
		.re    (pop),
		.rdata (resq_rdata),
		.empty (empty)
	);

	assign out_res   = res_t'(resq_rdata);
	assign sample    = out_res.sample;
	assign active    = out_res.active;
	assign releasing = out_res.releasing;

	// back end reserves result room before taking a command
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_we |-> !res_full)
		else $error("result word written into a full result queue");

	a_cmd_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("back end took a command from an empty queue");

	a_rel_active: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && releasing) |-> active)
		else $error("release flagged on a silent voice");

endmodule

`default_nettype wire

[bench/sine_voice_with_release_top_test.sv]
// Self-checking bench for sine_voice_with_release_top: directed script, then random note sequences.
// Result words are checked against an in-bench voice predictor; needs svwr_pkg and the block RTL.
`default_nettype none

module sine_voice_with_release_top_test;
	import svwr_pkg::*;

	localparam int unsigned OSC_RATE   = 48000;
	localparam logic [16:0] FADE_START = 17'd65536;
	localparam logic [63:0] FADE_MUL   = 64'd64881;
	localparam logic [16:0] FADE_STOP  = 17'd327;
	localparam int          RANDOM_WORDS = 400;
	localparam int          DRAIN_CYCLES = 16;

	// note frequencies of the lowest octave in Q24 Hz
	localparam logic [63:0] BASE_FREQ [0:11] = '{
		64'd137167144, 64'd145323527, 64'd153964914, 64'd163120144,
		64'd172819773, 64'd183096171, 64'd193983636, 64'd205518503,
		64'd217739269, 64'd230686720, 64'd244404066, 64'd258937088
	};

	typedef struct packed {
		op_t        op;
		logic [6:0] key;
		logic [6:0] vel;
		logic       fade_ok;
		logic       fixed;
		res_t       want;
	} script_row_t;

	localparam res_t QUIET   = '{16'sd0, 1'b0, 1'b0};
	localparam res_t HELD    = '{16'sd0, 1'b1, 1'b0};
	localparam res_t FADING  = '{16'sd0, 1'b1, 1'b1};
	localparam int   SCRIPT_LEN = 25;

	// rows with fixed set are checked against the typed word, the rest against the predictor
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{OP_TICK, 7'd0,   7'd0,   1'b0, 1'b1, QUIET},   // tick right after reset
		'{OP_OFF,  7'd127, 7'd127, 1'b1, 1'b1, QUIET},   // note off on a silent voice
		'{OP_NOP,  7'd127, 7'd127, 1'b1, 1'b1, QUIET},
		'{OP_ON,   7'd127, 7'd127, 1'b0, 1'b1, HELD},
		'{OP_TICK, 7'd0,   7'd0,   1'b0, 1'b1, HELD},    // phase zero, sine zero
		'{OP_TICK, 7'd127, 7'd127, 1'b1, 1'b0, QUIET},
		'{OP_TICK, 7'd0,   7'd0,   1'b0, 1'b0, QUIET},
		'{OP_OFF,  7'd0,   7'd0,   1'b1, 1'b1, FADING},
		'{OP_TICK, 7'd0,   7'd0,   1'b0, 1'b0, QUIET},
		'{OP_OFF,  7'd127, 7'd127, 1'b1, 1'b1, FADING},  // off again while fading
		'{OP_TICK, 7'd0,   7'd0,   1'b0, 1'b0, QUIET},
		'{OP_NOP,  7'd0,   7'd0,   1'b0, 1'b1, FADING},
		'{OP_OFF,  7'd127, 7'd127, 1'b0, 1'b1, QUIET},   // hard stop cuts the fade
		'{OP_TICK, 7'd127, 7'd127, 1'b1, 1'b1, QUIET},
		'{OP_OFF,  7'd0,   7'd0,   1'b0, 1'b1, QUIET},
		'{OP_ON,   7'd0,   7'd0,   1'b1, 1'b1, HELD},    // zero velocity, lowest note
		'{OP_TICK, 7'd0,   7'd0,   1'b0, 1'b1, HELD},
		'{OP_TICK, 7'd0,   7'd0,   1'b0, 1'b1, HELD},
		'{OP_ON,   7'd69,  7'd64,  1'b0, 1'b1, HELD},
		'{OP_TICK, 7'd0,   7'd0,   1'b0, 1'b0, QUIET},
		'{OP_TICK, 7'd0,   7'd0,   1'b0, 1'b0, QUIET},
		'{OP_TICK, 7'd0,   7'd0,   1'b0, 1'b0, QUIET},
		'{OP_OFF,  7'd0,   7'd0,   1'b1, 1'b1, FADING},
		'{OP_ON,   7'd60,  7'd127, 1'b1, 1'b1, HELD},    // note on clears the fade
		'{OP_TICK, 7'd0,   7'd0,   1'b0, 1'b0, QUIET}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    push;
	logic                    full;
	logic [1:0]              kind;
	logic [6:0]              note;
	logic [6:0]              velocity;
	logic                    allow_release;
	logic                    empty;
	logic                    pop;
	logic signed [SMP_W-1:0] sample;
	logic                    active;
	logic                    releasing;

	// voice state as predicted
	logic [31:0] osc_phase;
	logic [31:0] osc_step;
	logic [15:0] osc_gain;
	logic [16:0] fade_gain;

	res_t        expected_words [$];
	logic        row_fixed;
	res_t        row_want;
	logic        calm;
	int          mismatches;
	int          words_checked;
	int          note_ons;
	int          ticks_seen;
	int          fades_ended;

	sine_voice_with_release_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.kind          (kind),
		.note          (note),
		.velocity      (velocity),
		.allow_release (allow_release),
		.empty         (empty),
		.pop           (pop),
		.sample        (sample),
		.active        (active),
		.releasing     (releasing)
	);

	always begin
		#1 clk = 1'b0;
		#1 clk = 1'b1;
	end

	function automatic logic [31:0] note_increment(input logic [6:0] key);
		logic [63:0] freq;
		logic [63:0] inc;
		freq = BASE_FREQ[key % 12] << (key / 12);
		// Q24 Hz to a 2^32 phase cycle: scale by 2^8, divide by the rate
		inc = (freq << 8) / OSC_RATE;
		if (inc[31:0] == 32'd0)
			return 32'd1;
		return inc[31:0];
	endfunction

	// Q1.15 sine at a 10-bit table index, quarter-wave folded polynomial
	function automatic logic signed [15:0] wave_at(input logic [9:0] idx);
		logic [8:0]  j;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] p;
		logic [63:0] v;
		j = {1'b0, idx[7:0]};
		if (idx[8])
			j = 9'd256 - j;
		x  = 64'(j) << 22;
		x2 = (x * x) >> 30;
		p  = 64'd172273;
		p  = 64'd5026995 - ((x2 * p) >> 30);
		p  = 64'd85569306 - ((x2 * p) >> 30);
		p  = 64'd693598668 - ((x2 * p) >> 30);
		p  = 64'd1686629713 - ((x2 * p) >> 30);
		v  = (x * p) >> 30;
		v  = (v + 64'd16384) >> 15;
		if (v > 64'd32767)
			v = 64'd32767;
		return idx[9] ? -$signed(v[15:0]) : $signed(v[15:0]);
	endfunction

	task automatic voice_word(input op_t op, input logic [6:0] key, input logic [6:0] vel,
			input logic fade_ok, output res_t res);
		int          wave;
		logic [63:0] mag;
		res.sample = '0;
		case (op)
			OP_ON: begin
				note_ons++;
				osc_phase = '0;
				osc_gain  = 16'((32'(vel) * 32'd65536 + 32'd635) / 32'd1270);
				fade_gain = '0;
				osc_step  = note_increment(key);
			end
			OP_OFF: begin
				if (osc_step != 0) begin
					if (!fade_ok) begin
						osc_step  = '0;
						fade_gain = '0;
					end else if (fade_gain == 0) begin
						fade_gain = FADE_START;
					end
				end
			end
			OP_TICK: begin
				ticks_seen++;
				if (osc_step != 0) begin
					wave = wave_at(osc_phase[31:22]);
					mag  = 64'(wave < 0 ? -wave : wave);
					mag  = (mag * osc_gain + 64'd16384) >> 15;
					if (fade_gain != 0)
						mag = (mag * fade_gain + 64'd32768) >> 16;
					if (mag > 64'd32767)
						mag = 64'd32767;
					res.sample = wave < 0 ? -$signed(mag[15:0]) : $signed(mag[15:0]);
					osc_phase  = osc_phase + osc_step;
					if (fade_gain != 0) begin
						fade_gain = 17'((64'(fade_gain) * FADE_MUL + 64'd32768) >> 16);
						if (fade_gain <= FADE_STOP) begin
							osc_step  = '0;
							fade_gain = '0;
							fades_ended++;
						end
					end
				end
			end
			default: ;
		endcase
		res.active    = osc_step != 0;
		res.releasing = fade_gain != 0;
	endtask

	always @(posedge clk) begin : scoreboard
		res_t want;
		if (arst_n) begin
			if (push && !full) begin
				voice_word(op_t'(kind), note, velocity, allow_release, want);
				if (row_fixed)
					want = row_want;
				expected_words.push_back(want);
			end
			if (pop && !empty) begin
				words_checked++;
				if (expected_words.size() == 0) begin
					$error("unexpected result word: sample %0d active %0b releasing %0b",
						sample, active, releasing);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (sample !== want.sample) begin
						$error("sample: expected %0d, got %0d", want.sample, sample);
						mismatches++;
					end
					if (active !== want.active) begin
						$error("active: expected %0b, got %0b", want.active, active);
						mismatches++;
					end
					if (releasing !== want.releasing) begin
						$error("releasing: expected %0b, got %0b", want.releasing, releasing);
						mismatches++;
					end
				end
			end
		end
	end

	task automatic send_word(input op_t op, input logic [6:0] key, input logic [6:0] vel,
			input logic fade_ok, input logic fixed, input res_t want);
		bit taken;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			if (!calm && $urandom_range(99) < 38) begin
				push          = 1'b0;
				kind          = 2'($urandom);
				note          = 7'($urandom);
				velocity      = 7'($urandom);
				allow_release = 1'($urandom);
			end else begin
				push          = 1'b1;
				kind          = op;
				note          = key;
				velocity      = vel;
				allow_release = fade_ok;
				row_fixed     = fixed;
				row_want      = want;
				@(posedge clk);
				taken = !full;
			end
		end
	endtask

	task automatic send_ticks(input int count);
		repeat (count)
			send_word(OP_TICK, 7'($urandom), 7'($urandom), 1'($urandom), 1'b0, QUIET);
	endtask

	initial begin
		pop = 1'b0;
		@(negedge clk);
		forever begin
			@(negedge clk);
			pop = calm || ($urandom_range(99) >= 38);
		end
	end

	initial begin
		#400000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		int   random_words;
		int   pick;
		int   n;
		op_t  op;
		logic [6:0] vel;
		clk           = 1'b0;
		arst_n        = 1'b0;
		push          = 1'b0;
		kind          = '0;
		note          = '0;
		velocity      = '0;
		allow_release = 1'b0;
		row_fixed     = 1'b0;
		row_want      = QUIET;
		calm          = 1'b0;
		osc_phase     = '0;
		osc_step      = '0;
		osc_gain      = '0;
		fade_gain     = '0;
		mismatches    = 0;
		words_checked = 0;
		note_ons      = 0;
		ticks_seen    = 0;
		fades_ended   = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < SCRIPT_LEN; r++)
			send_word(SCRIPT[r].op, SCRIPT[r].key, SCRIPT[r].vel, SCRIPT[r].fade_ok,
				SCRIPT[r].fixed, SCRIPT[r].want);

		random_words = 0;
		while (random_words < RANDOM_WORDS) begin
			calm = random_words >= 120 && random_words < 200;
			pick = $urandom_range(99);
			if (pick < 80) begin
				case ($urandom_range(7))
					0:       vel = 7'd0;
					1:       vel = 7'd127;
					default: vel = 7'($urandom);
				endcase
				send_word(OP_ON, 7'($urandom), vel, 1'($urandom), 1'b0, QUIET);
				n = $urandom_range(24, 1);
				send_ticks(n);
				random_words += 1 + n;
				if ($urandom_range(3) != 0) begin
					send_word(OP_OFF, 7'($urandom), 7'($urandom),
						$urandom_range(3) != 0, 1'b0, QUIET);
					n = $urandom_range(24);
					send_ticks(n);
					random_words += 1 + n;
					if ($urandom_range(4) == 0) begin
						send_word(OP_OFF, 7'($urandom), 7'($urandom), 1'($urandom),
							1'b0, QUIET);
						send_ticks(2);
						random_words += 3;
					end
				end
			end else begin
				repeat ($urandom_range(4, 1)) begin
					op = op_t'($urandom_range(3));
					send_word(op, 7'($urandom), 7'($urandom), 1'($urandom), 1'b0, QUIET);
					if (op != OP_NOP)
						random_words++;
				end
			end
		end
		calm = 1'b0;
		@(negedge clk);
		push = 1'b0;

		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d result words: %0d note-ons, %0d ticks, %0d fades ran out",
			words_checked, note_ons, ticks_seen, fades_ended);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/svwr_pkg.sv
hw/rtl/svwr_fifo.sv
hw/rtl/svwr_front.sv
hw/rtl/svwr_back.sv
hw/rtl/sine_voice_with_release_top.sv
bench/sine_voice_with_release_top_test.sv
